/* design/line_gated_char_ring_buffer_assert.svh */
// Assertion macros for the line-gated character ring buffer.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef LINE_GATED_CHAR_RING_BUFFER_ASSERT_SVH
`define LINE_GATED_CHAR_RING_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGCRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGCRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lgcrb_pkg.sv */
`default_nettype none

package lgcrb_pkg;

    localparam int CAPACITY_DEF = 63;
    localparam int CHAR_W       = 8;
    localparam int CNT_W        = 6;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        REQ_PUT      = 2'd0,
        REQ_GET_CHAR = 2'd1,
        REQ_GET_LINE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NO_LINE = 2'd3
    } stat_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        stat_t             status;
        logic              last;
        logic              line_ready;
        logic [CNT_W-1:0]  occupancy;
        logic              is_empty;
        logic              is_full;
    } res_t;

endpackage

`default_nettype wire

/* design/lgcrb_ram.sv */
`default_nettype none

module lgcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds while re is low, so a stalled pop keeps its byte.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/lgcrb_ctrl.sv */
`default_nettype none

module lgcrb_ctrl
    import lgcrb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int PTR_W = $clog2(CAPACITY + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        req_type,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              out_free,
    output logic                   res_load,
    output res_t                   res,
    output logic                   ram_we,
    output logic      [PTR_W-1:0]  ram_waddr,
    output logic      [CHAR_W-1:0] ram_wdata,
    output logic                   ram_re,
    output logic      [PTR_W-1:0]  ram_raddr,
    input  wire logic [CHAR_W-1:0] ram_rdata
);

    state_t           state_reg, state_next;
    logic             line_mode_reg, line_mode_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pend_reg, pend_next;

    logic              accept;
    logic [CHAR_W-1:0] put_char;
    logic              pop_nl;
    logic              pop_fin;
    logic [CNT_W-1:0]  res_occ;

    // Pointers wrap at CAPACITY+1 slots.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_mode_reg <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_mode_reg <= line_mode_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        line_mode_next = line_mode_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = char_in;
        ram_re    = 1'b0;
        ram_raddr = rp_reg;

        res_load       = 1'b0;
        res.char_out   = '0;
        res.status     = ST_OK;
        res.last       = 1'b1;
        res_occ        = fill_reg;

        in_stall = (state_reg != S_IDLE) || !out_free;
        accept   = in_valid && !in_stall;

        // The put that would fill the buffer is forced to a newline, closing the line.
        put_char = (fill_reg >= CNT_W'(CAPACITY - 1)) ? NEWLINE : char_in;
        pop_nl   = (ram_rdata == NEWLINE);
        pop_fin  = !line_mode_reg || pop_nl || (fill_reg == '0);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_PUT:
                        begin
                            res_load = 1'b1;
                            if (pend_reg || (fill_reg >= CNT_W'(CAPACITY)))
                            begin
                                res.status = ST_REFUSED;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = put_char;
                                wp_next   = ptr_inc(wp_reg);
                                fill_next = CNT_W'(fill_reg + 1'b1);
                                pend_next = pend_reg || (put_char == NEWLINE);
                                res_occ   = fill_next;
                            end
                        end
                        REQ_GET_CHAR, REQ_GET_LINE:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else if ((req_type == REQ_GET_LINE) && !pend_reg)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_NO_LINE;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                rp_next        = ptr_inc(rp_reg);
                                fill_next      = CNT_W'(fill_reg - 1'b1);
                                line_mode_next = (req_type == REQ_GET_LINE);
                                state_next     = S_POP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // The count was already lowered when the read was issued.
                if (out_free)
                begin
                    res_load     = 1'b1;
                    res.char_out = ram_rdata;
                    res.last     = pop_fin;
                    pend_next    = pend_reg && !pop_nl;
                    if (pop_fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        rp_next   = ptr_inc(rp_reg);
                        fill_next = CNT_W'(fill_reg - 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.line_ready = pend_next;
        res.occupancy  = res_occ;
        res.is_empty   = (res_occ == '0);
        res.is_full    = (res_occ == CNT_W'(CAPACITY));
    end

endmodule

`default_nettype wire

/* design/line_gated_char_ring_buffer.sv */
// Line-gated receive character buffer.
// Input channel: in_valid/in_stall carry a request word (req_type, char_in):
// put a byte, pop one byte, or pop a whole line up to and including the newline.
// Output channel: out_valid/out_stall carry one result word per put or error,
// one per popped byte, with last set on the final word of each request.
// Puts and refused or erroneous requests give their word in the cycle after
// acceptance. A pop reads the synchronous byte store first, so its first word
// passes the store's read register and then the output register; a line then
// streams one byte per cycle while the output is free. Unknown request codes
// are accepted and give no word. Throughput: one put per cycle while the output
// is free; a pop holds off new requests until its last byte is loaded.
// The next request is accepted once the previous one has loaded its last word
// and the output register is empty or being drained in that cycle.
// When out_stall is held, the output register keeps its word and in_stall rises.
// Reset clears pointers, count and the line mark at once; the byte store is not
// cleared, and needs no clearing pass since only written bytes are ever popped.
`default_nettype none

`include "line_gated_char_ring_buffer_assert.svh"

module line_gated_char_ring_buffer
    import lgcrb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        req_type,
    input  wire logic [CHAR_W-1:0] char_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [CHAR_W-1:0] char_out,
    output logic      [1:0]        status,
    output logic                   last,
    output logic                   line_ready,
    output logic      [CNT_W-1:0]  occupancy,
    output logic                   is_empty,
    output logic                   is_full
);

    localparam int SLOTS = CAPACITY + 1;
    localparam int PTR_W = $clog2(SLOTS);

    logic              out_valid_reg, out_valid_next;
    res_t              res_reg;
    res_t              res;
    logic              res_load;
    logic              out_free;
    logic              in_acc;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && !in_stall;

    lgcrb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .char_in   (char_in),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lgcrb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_out   = res_reg.char_out;
    assign status     = res_reg.status;
    assign last       = res_reg.last;
    assign line_ready = res_reg.line_ready;
    assign occupancy  = res_reg.occupancy;
    assign is_empty   = res_reg.is_empty;
    assign is_full    = res_reg.is_full;

    // A new word must never overwrite one that is still waiting.
    `LGCRB_ASSERT_SAME(a_no_overwrite, res_load, out_free, "result word overwritten")
    // A put always answers in the cycle it is accepted.
    `LGCRB_ASSERT_SAME(a_put_answers, in_acc && (req_type == REQ_PUT), res_load,
        "accepted put gave no word")
    // A full buffer always holds the forced newline.
    `LGCRB_ASSERT_SAME(a_full_has_line, out_valid && is_full, line_ready,
        "full buffer without a pending line")
    // While a line is still streaming, no new request may enter.
    `LGCRB_ASSERT_NEXT(a_line_blocks, res_load && !res.last, in_stall,
        "request accepted during a line")

endmodule

`default_nettype wire
